FILE: src/sle_pkg.sv
// Package for the sorted list engine.
// Holds the command and result word types, the cell control struct and codes.
// No dependencies.
package sle_pkg;

  typedef logic signed [31:0] word_t;

  // Command codes.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // One command word.
  typedef struct packed {
    logic [1:0] command;
    word_t      value;
  } cmd_word_t;

  // One result word.
  typedef struct packed {
    logic [1:0] status;
    logic [4:0] entry_count;
    word_t      popped_value;
    logic [4:0] removed_count;
    logic       head_valid;
    word_t      head_value;
  } rsp_word_t;

  // Operation that every cell of the chain performs.
  typedef enum logic [1:0] {
    OP_HOLD     = 2'd0,
    OP_INSERT   = 2'd1,
    OP_POP      = 2'd2,
    OP_DEL_STEP = 2'd3
  } cell_op_t;

  // Control broadcast to all cells.
  typedef struct packed {
    cell_op_t op;
    word_t    key;
  } cell_ctl_t;

endpackage

FILE: src/sle_cell.sv
// One storage cell of the sorted chain: a value and its occupancy bit.
// Exchanges data with its two neighbors only. Depends on sle_pkg.
module sle_cell import sle_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      left_ge,
  input  word_t     left_value,
  input  logic      left_valid,
  input  word_t     right_value,
  input  logic      right_valid,
  output word_t     cell_value,
  output logic      cell_valid,
  output logic      ge,
  output logic      eq
);

  word_t value_next;
  logic  valid_next;

  // An empty cell counts as greater than any key, so the ge flags stay monotone.
  assign ge = !cell_valid || (cell_value >= ctl.key);
  assign eq = cell_valid && (cell_value == ctl.key);

  // Local update rule for each operation.
  always_comb begin
    value_next = cell_value;
    valid_next = cell_valid;
    case (ctl.op)
      OP_INSERT: begin
        if (left_ge) begin
          value_next = left_value;
          valid_next = left_valid;
        end else if (ge) begin
          value_next = ctl.key;
          valid_next = 1'b1;
        end
      end
      OP_POP: begin
        value_next = right_value;
        valid_next = right_valid;
      end
      OP_DEL_STEP: begin
        if (ge) begin
          value_next = right_value;
          valid_next = right_valid;
        end
      end
      default: begin
        value_next = cell_value;
        valid_next = cell_valid;
      end
    endcase
  end

  // The value carries no reset; only the occupancy bit is cleared.
  always_ff @(posedge clk) begin
    cell_value <= value_next;
    if (rst) begin
      cell_valid <= 1'b0;
    end else begin
      cell_valid <= valid_next;
    end
  end

endmodule

FILE: src/sle_chain.sv
// Row of sorted storage cells with neighbor links and a match flag.
// Depends on sle_pkg and sle_cell.
module sle_chain import sle_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  output word_t     head_value,
  output logic      head_valid,
  output logic      any_eq
);

  word_t            values [DEPTH];
  logic [DEPTH-1:0] valids;
  logic [DEPTH-1:0] ges;
  logic [DEPTH-1:0] eqs;

  // Each cell sees its left neighbor's ge flag and both neighbors' contents.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic  l_ge;
    word_t l_value;
    logic  l_valid;
    word_t r_value;
    logic  r_valid;

    if (i == 0) begin : g_first
      assign l_ge    = 1'b0;
      assign l_value = '0;
      assign l_valid = 1'b0;
    end else begin : g_mid
      assign l_ge    = ges[i-1];
      assign l_value = values[i-1];
      assign l_valid = valids[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_value = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_value = values[i+1];
      assign r_valid = valids[i+1];
    end

    sle_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .left_ge     (l_ge),
      .left_value  (l_value),
      .left_valid  (l_valid),
      .right_value (r_value),
      .right_valid (r_valid),
      .cell_value  (values[i]),
      .cell_valid  (valids[i]),
      .ge          (ges[i]),
      .eq          (eqs[i])
    );
  end

  // The smallest entry always sits in the first cell.
  assign head_value = values[0];
  assign head_valid = valids[0];
  assign any_eq     = |eqs;

endmodule

FILE: src/sorted_list_engine_top.sv
// Top level of the sorted list engine: command decode, entry count and result.
// Depends on sle_pkg and sle_chain.
//
//   Channel   Direction  Handshake                     Word
//   command   in         start high, busy low          cmd    (cmd_word_t)
//   result    out        done high for one cycle       result (rsp_word_t)
//
// Insert, pop and unused codes are executed at the accepting edge; the result
// follows in the next cycle with busy low, so these commands run one per cycle.
// Delete removes one matching entry per cycle, one shift step of the chain, and
// holds busy until no match is left; then it reports.
// Synchronous active-high reset empties the list; stored values keep no reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_list_engine_top import sle_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  cmd_word_t cmd,
  output logic      done,
  output rsp_word_t result
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DEL  = 2'b10
  } state_t;

  state_t       state;
  state_t       state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] removed;
  logic [1:0]   status;
  word_t        popped;
  word_t        del_key;

  cell_ctl_t    ctl;
  word_t        chain_head;
  logic         chain_head_valid;
  logic         any_eq;
  logic         accept;
  logic         full;
  logic         empty;
  logic [CW+4:0] count_ext;
  logic [CW+4:0] removed_ext;

  assign accept = start && !busy;
  assign busy   = (state == S_DEL);
  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);

  // Chain operation for this cycle.
  always_comb begin
    ctl.key = (state == S_DEL) ? del_key : cmd.value;
    ctl.op  = OP_HOLD;
    if (state == S_DEL) begin
      ctl.op = any_eq ? OP_DEL_STEP : OP_HOLD;
    end else if (accept) begin
      unique case (cmd.command)
        CMD_INSERT: ctl.op = full ? OP_HOLD : OP_INSERT;
        CMD_POP:    ctl.op = empty ? OP_HOLD : OP_POP;
        default:    ctl.op = OP_HOLD;
      endcase
    end
  end

  sle_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .head_value (chain_head),
    .head_valid (chain_head_valid),
    .any_eq     (any_eq)
  );

  // Next state of the controller.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept && cmd.command == CMD_DELETE) state_next = S_DEL;
      S_DEL:  if (!any_eq) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers: state, entry count and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == S_DEL) begin
        if (any_eq) begin
          count <= count - CW'(1);
        end else begin
          done <= 1'b1;
        end
      end else if (accept) begin
        done <= (cmd.command != CMD_DELETE);
        if (ctl.op == OP_INSERT) begin
          count <= count + CW'(1);
        end else if (ctl.op == OP_POP) begin
          count <= count - CW'(1);
        end
      end
    end
  end

  // Result fields held until the strobe.
  always_ff @(posedge clk) begin
    if (state == S_DEL) begin
      if (any_eq) begin
        removed <= removed + CW'(1);
      end
    end else if (accept) begin
      del_key <= cmd.value;
      status  <= ST_OK;
      popped  <= '0;
      removed <= '0;
      unique case (cmd.command)
        CMD_INSERT: begin
          if (full) begin
            status <= ST_FULL;
          end
        end
        CMD_POP: begin
          if (empty) begin
            status <= ST_EMPTY;
          end else begin
            popped  <= chain_head;
            removed <= CW'(1);
          end
        end
        default: begin
          status <= ST_OK;
        end
      endcase
    end
  end

  // Counts are reported in a 5-bit field.
  assign count_ext   = {5'd0, count};
  assign removed_ext = {5'd0, removed};

  always_comb begin
    result.status        = status;
    result.entry_count   = count_ext[4:0];
    result.popped_value  = popped;
    result.removed_count = removed_ext[4:0];
    result.head_valid    = !empty;
    result.head_value    = empty ? word_t'(0) : chain_head;
  end

  // The entry count never exceeds the depth of the chain.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  // The first cell is occupied exactly when the count is nonzero.
  a_head_matches_count: assert property (@(posedge clk) disable iff (rst)
    chain_head_valid == !empty)
    else $error("head occupancy disagrees with count");

  // An insert into a list with room reports in the next cycle with one more entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.command == CMD_INSERT && !full
    |=> done && count == $past(count) + CW'(1))
    else $error("insert did not add an entry");

  // A delete pass with no remaining match ends and reports next cycle.
  a_delete_ends: assert property (@(posedge clk) disable iff (rst)
    state == S_DEL && !any_eq |=> done && !busy)
    else $error("delete did not finish");

endmodule
